@@ rtl/core/fbfsa_pkg.sv @@
`timescale 1ns / 1ps
// fbfsa_pkg: sizes, codes and shared types of the fixed block free stack allocator
// used by fbfsa_stack_ram, fbfsa_div and fixed_block_free_stack_allocator; no dependencies
package fbfsa_pkg;

	localparam int MAX_BUCKETS = 256;
	localparam int ADDR_BITS   = 32;
	localparam int ENTRY_BYTES = 8;

	localparam int IDX_W   = $clog2(MAX_BUCKETS);
	localparam int CNT_W   = $clog2(MAX_BUCKETS + 1);
	localparam int DATA_W  = 32;
	localparam int BSIZE_W = 21;
	localparam int DVS_W   = BSIZE_W + 1;
	localparam int PROD_W  = CNT_W + BSIZE_W;
	localparam int INFO_W  = 33;

	localparam logic [DATA_W-1:0] ADDR_MASK = (ADDR_BITS >= DATA_W) ? {DATA_W{1'b1}} :
		DATA_W'((64'd1 << ADDR_BITS) - 64'd1);

	// actions
	localparam logic [1:0] ACT_INIT  = 2'd0;
	localparam logic [1:0] ACT_ALLOC = 2'd1;
	localparam logic [1:0] ACT_FREE  = 2'd2;
	localparam logic [1:0] ACT_QUERY = 2'd3;

	// result status
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_TOO_LARGE = 3'd1;
	localparam logic [2:0] ST_EMPTY     = 3'd2;
	localparam logic [2:0] ST_FOREIGN   = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	// statistic selectors
	localparam logic [3:0] KIND_USED_BLOCKS = 4'd0;
	localparam logic [3:0] KIND_MAX_BLOCKS  = 4'd1;
	localparam logic [3:0] KIND_USED_MEM    = 4'd2;
	localparam logic [3:0] KIND_MAX_MEM     = 4'd3;
	localparam logic [3:0] KIND_FRAGMENTS   = 4'd4;
	localparam logic [3:0] KIND_LARGEST     = 4'd5;
	localparam logic [3:0] KIND_FREE_BLOCKS = 4'd6;
	localparam logic [3:0] KIND_HI_ADDR     = 4'd7;
	localparam logic [3:0] KIND_LO_ADDR     = 4'd8;
	localparam logic [3:0] KIND_MAX_USED    = 4'd9;
	localparam logic [3:0] KIND_FREE_MEM    = 4'd10;

	// register indexes
	localparam logic [1:0] REG_BASE   = 2'd0;
	localparam logic [1:0] REG_REGION = 2'd1;
	localparam logic [1:0] REG_BSIZE  = 2'd2;

	typedef struct packed {
		logic              re;
		logic              we;
		logic [IDX_W-1:0]  addr;
		logic [DATA_W-1:0] wdata;
	} mem_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quotient;
	} div_rsp_t;

endpackage

@@ rtl/core/fbfsa_stack_ram.sv @@
`timescale 1ns / 1ps
// fbfsa_stack_ram: single-port free stack storage, registered read
// depends on fbfsa_pkg
module fbfsa_stack_ram (
	input  logic                          clk,
	input  fbfsa_pkg::mem_req_t           req,
	output logic [fbfsa_pkg::DATA_W-1:0]  rdata
);

	logic [fbfsa_pkg::DATA_W-1:0] mem [fbfsa_pkg::MAX_BUCKETS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.addr];
		end
	end

endmodule

@@ rtl/core/fbfsa_div.sv @@
`timescale 1ns / 1ps
// fbfsa_div: restoring divider, one quotient bit per cycle, for the bucket count
// depends on fbfsa_pkg
module fbfsa_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [fbfsa_pkg::DATA_W-1:0]  dividend,
	input  logic [fbfsa_pkg::DVS_W-1:0]   divisor,
	output fbfsa_pkg::div_rsp_t           rsp
);

	localparam int STEP_W = $clog2(fbfsa_pkg::DATA_W);

	logic                          busy_q;
	logic                          done_q;
	logic [STEP_W-1:0]             step_q;
	logic [fbfsa_pkg::DVS_W-1:0]   rem_q;
	logic [fbfsa_pkg::DVS_W-1:0]   dvs_q;
	logic [fbfsa_pkg::DATA_W-1:0]  dq_q;
	logic [fbfsa_pkg::DVS_W:0]     trial;
	logic [fbfsa_pkg::DVS_W:0]     diff;
	logic                          ge;

	assign trial = {rem_q, dq_q[fbfsa_pkg::DATA_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(fbfsa_pkg::DATA_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// quotient bits shift in from the bottom as dividend bits leave the top
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			dq_q  <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[fbfsa_pkg::DVS_W-1:0] : trial[fbfsa_pkg::DVS_W-1:0];
			dq_q  <= {dq_q[fbfsa_pkg::DATA_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dq_q;

endmodule

@@ rtl/core/fixed_block_free_stack_allocator.sv @@
`timescale 1ns / 1ps
// fixed_block_free_stack_allocator: top level, APB registers, control and statistics
// depends on fbfsa_pkg, fbfsa_stack_ram, fbfsa_div
//
// Hands out equal-sized buckets of a memory region from a stack of free bucket
// addresses held in a 256-entry synchronous RAM. Allocate, free and query items
// pass through accept, an execute step with at most one stack RAM access (pop
// read or push write) and the pointer update, then the result register. An init
// item gets the new bucket count from a bit-serial divider, saturated to 256,
// and the stack is then filled one entry per cycle through the single RAM write
// port. The next item may be accepted while a result still waits on the output
// side. The stack RAM needs no clearing after reset; only entries below the
// stack top are ever read. Registers base_address, region_size and bucket_size
// sit at byte addresses 0, 4 and 8; the user must write them only while the
// block is idle, and the block itself does not enforce this.
module fixed_block_free_stack_allocator (
	input  logic        clk,
	input  logic        arst_n,
	// stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // request_size[31:0], free_address[63:32]
	input  logic [7:0]  s_tuser,  // action[1:0], info_kind[5:2], zero[7:6]
	// stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // bucket_address[31:0], info_value[64:32], zero[71:65]
	output logic [7:0]  m_tuser,  // status[2:0], zero[7:3]
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IDX_W   = fbfsa_pkg::IDX_W;
	localparam int CNT_W   = fbfsa_pkg::CNT_W;
	localparam int DATA_W  = fbfsa_pkg::DATA_W;
	localparam int BSIZE_W = fbfsa_pkg::BSIZE_W;
	localparam int PROD_W  = fbfsa_pkg::PROD_W;
	localparam int INFO_W  = fbfsa_pkg::INFO_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_FILL = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(fbfsa_pkg::MAX_BUCKETS);

	// configuration registers
	logic [DATA_W-1:0]  base_q;
	logic [DATA_W-1:0]  region_q;
	logic [BSIZE_W-1:0] bsize_q;
	logic               cfg_wr;

	// control and state
	logic [2:0]         state_q;
	logic [CNT_W-1:0]   top_q;
	logic [CNT_W-1:0]   total_q;
	logic [DATA_W-1:0]  largest_q;
	logic [CNT_W-1:0]   n_q;
	logic [IDX_W-1:0]   fill_idx_q;
	logic [DATA_W-1:0]  acc_q;
	logic [2:0]         status_q;
	logic               rd_pend_q;
	logic [PROD_W-1:0]  prod_q;

	// latched item
	logic [1:0]         act_q;
	logic [DATA_W-1:0]  req_q;
	logic [DATA_W-1:0]  faddr_q;
	logic [3:0]         kind_q;

	// result register
	logic               m_tvalid_q;
	logic [2:0]         m_status_q;
	logic [DATA_W-1:0]  m_addr_q;
	logic [INFO_W-1:0]  m_info_q;

	logic                    s_accept;
	logic                    out_load;
	logic                    alloc_big;
	logic                    alloc_empty;
	logic                    free_foreign;
	logic                    free_full;
	logic [DATA_W:0]         hi_addr;
	logic [CNT_W-1:0]        used;
	logic [CNT_W-1:0]        top_m1;
	logic [CNT_W-1:0]        mul_op;
	logic [PROD_W-1:0]       mul_full;
	logic [CNT_W-1:0]        n_sat;
	logic [CNT_W-1:0]        fill_next;
	logic [INFO_W-1:0]       info_sel;
	logic [DATA_W-1:0]       mem_rdata;
	fbfsa_pkg::mem_req_t     mem_req;
	fbfsa_pkg::div_rsp_t     div_rsp;
	logic                    div_start;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			region_q <= '0;
			bsize_q  <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				fbfsa_pkg::REG_BASE:   base_q   <= pwdata;
				fbfsa_pkg::REG_REGION: region_q <= pwdata;
				fbfsa_pkg::REG_BSIZE:  bsize_q  <= pwdata[BSIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			fbfsa_pkg::REG_BASE:   prdata = base_q;
			fbfsa_pkg::REG_REGION: prdata = region_q;
			fbfsa_pkg::REG_BSIZE:  prdata = 32'(bsize_q);
			default:               prdata = '0;
		endcase
	end

	// ---------------- datapath ----------------
	assign s_tready = (state_q == S_IDLE);
	assign s_accept = s_tvalid & s_tready;
	assign out_load = (state_q == S_FIN) & (~m_tvalid_q | m_tready);

	assign hi_addr      = {1'b0, base_q} + {1'b0, region_q};
	assign alloc_big    = req_q > DATA_W'(bsize_q);
	assign alloc_empty  = (top_q == '0);
	assign free_foreign = (faddr_q < base_q) | ({1'b0, faddr_q} >= hi_addr);
	assign free_full    = (top_q >= total_q) | (top_q >= MAX_CNT);
	assign used         = total_q - top_q;
	assign top_m1       = top_q - 1'b1;
	assign fill_next    = CNT_W'(fill_idx_q) + 1'b1;

	always_comb begin
		unique case (kind_q)
			fbfsa_pkg::KIND_USED_MEM: mul_op = used;
			fbfsa_pkg::KIND_MAX_MEM:  mul_op = total_q;
			default:                  mul_op = top_q;
		endcase
	end

	assign mul_full = PROD_W'(mul_op) * PROD_W'(bsize_q);

	assign n_sat = (div_rsp.quotient > DATA_W'(fbfsa_pkg::MAX_BUCKETS)) ? MAX_CNT :
		div_rsp.quotient[CNT_W-1:0];

	always_comb begin
		unique case (kind_q)
			fbfsa_pkg::KIND_USED_BLOCKS: info_sel = INFO_W'(used);
			fbfsa_pkg::KIND_MAX_BLOCKS:  info_sel = INFO_W'(total_q);
			fbfsa_pkg::KIND_USED_MEM:    info_sel = INFO_W'(prod_q);
			fbfsa_pkg::KIND_MAX_MEM:     info_sel = INFO_W'(prod_q);
			fbfsa_pkg::KIND_LARGEST:     info_sel = INFO_W'(largest_q);
			fbfsa_pkg::KIND_FREE_BLOCKS: info_sel = INFO_W'(top_q);
			fbfsa_pkg::KIND_HI_ADDR:     info_sel = INFO_W'(hi_addr);
			fbfsa_pkg::KIND_LO_ADDR:     info_sel = INFO_W'(base_q);
			fbfsa_pkg::KIND_FREE_MEM:    info_sel = INFO_W'(prod_q);
			default:                     info_sel = '0;
		endcase
	end

	// stack memory access: pop read, push write, or init fill write
	always_comb begin
		mem_req = '0;
		if (state_q == S_EXEC && act_q == fbfsa_pkg::ACT_ALLOC && !alloc_big && !alloc_empty) begin
			mem_req.re   = 1'b1;
			mem_req.addr = top_m1[IDX_W-1:0];
		end else if (state_q == S_EXEC && act_q == fbfsa_pkg::ACT_FREE &&
				!free_foreign && !free_full) begin
			mem_req.we    = 1'b1;
			mem_req.addr  = top_q[IDX_W-1:0];
			mem_req.wdata = faddr_q & fbfsa_pkg::ADDR_MASK;
		end else if (state_q == S_FILL) begin
			mem_req.we    = 1'b1;
			mem_req.addr  = fill_idx_q;
			mem_req.wdata = acc_q & fbfsa_pkg::ADDR_MASK;
		end
	end

	assign div_start = (state_q == S_EXEC) && (act_q == fbfsa_pkg::ACT_INIT);

	function automatic logic [fbfsa_pkg::DVS_W-1:0] DVS_W_EXT(input logic [BSIZE_W-1:0] bs);
		return fbfsa_pkg::DVS_W'(bs) + fbfsa_pkg::DVS_W'(fbfsa_pkg::ENTRY_BYTES);
	endfunction

	fbfsa_stack_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	fbfsa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (region_q),
		.divisor  (DVS_W_EXT(bsize_q)),
		.rsp      (div_rsp)
	);

	// latched item fields
	always_ff @(posedge clk) begin
		if (s_accept) begin
			act_q   <= s_tuser[1:0];
			kind_q  <= s_tuser[5:2];
			req_q   <= s_tdata[31:0];
			faddr_q <= s_tdata[63:32];
		end
		if (state_q == S_EXEC) begin
			prod_q <= mul_full;
		end
	end

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			top_q      <= '0;
			total_q    <= '0;
			largest_q  <= '0;
			n_q        <= '0;
			fill_idx_q <= '0;
			acc_q      <= '0;
			status_q   <= fbfsa_pkg::ST_OK;
			rd_pend_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (act_q)
						fbfsa_pkg::ACT_INIT: begin
							status_q  <= fbfsa_pkg::ST_OK;
							rd_pend_q <= 1'b0;
							state_q   <= S_DIV;
						end
						fbfsa_pkg::ACT_ALLOC: begin
							state_q <= S_FIN;
							if (req_q > largest_q) begin
								largest_q <= req_q;
							end
							priority if (alloc_big) begin
								status_q  <= fbfsa_pkg::ST_TOO_LARGE;
								rd_pend_q <= 1'b0;
							end else if (alloc_empty) begin
								status_q  <= fbfsa_pkg::ST_EMPTY;
								rd_pend_q <= 1'b0;
							end else begin
								status_q  <= fbfsa_pkg::ST_OK;
								top_q     <= top_m1;
								rd_pend_q <= 1'b1;
							end
						end
						fbfsa_pkg::ACT_FREE: begin
							state_q   <= S_FIN;
							rd_pend_q <= 1'b0;
							priority if (free_foreign) begin
								status_q <= fbfsa_pkg::ST_FOREIGN;
							end else if (free_full) begin
								status_q <= fbfsa_pkg::ST_FULL;
							end else begin
								status_q <= fbfsa_pkg::ST_OK;
								top_q    <= top_q + 1'b1;
							end
						end
						fbfsa_pkg::ACT_QUERY: begin
							status_q  <= fbfsa_pkg::ST_OK;
							rd_pend_q <= 1'b0;
							state_q   <= S_FIN;
						end
						default: ;
					endcase
				end
				S_DIV: begin
					if (div_rsp.done) begin
						n_q        <= n_sat;
						fill_idx_q <= '0;
						acc_q      <= base_q;
						if (n_sat == '0) begin
							total_q   <= '0;
							top_q     <= '0;
							largest_q <= '0;
							state_q   <= S_FIN;
						end else begin
							state_q <= S_FILL;
						end
					end
				end
				S_FILL: begin
					fill_idx_q <= fill_idx_q + 1'b1;
					acc_q      <= acc_q + DATA_W'(bsize_q);
					if (fill_next == n_q) begin
						total_q   <= n_q;
						top_q     <= n_q;
						largest_q <= '0;
						state_q   <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_status_q <= status_q;
			m_addr_q   <= rd_pend_q ? mem_rdata : '0;
			m_info_q   <= (act_q == fbfsa_pkg::ACT_QUERY) ? info_sel : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, m_info_q, m_addr_q};
	assign m_tuser  = {5'd0, m_status_q};

`ifndef ASSERT_OFF
	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= total_q)
		else $error("stack top above bucket total");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIV)
		else $error("divider finished outside init");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FILL |-> CNT_W'(fill_idx_q) < n_q)
		else $error("init fill beyond bucket count");

	a_fail_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_status_q != fbfsa_pkg::ST_OK) |-> m_addr_q == '0)
		else $error("failed item carries a bucket address");
`endif

endmodule
